// ----- hw/rtl/iirdf2_pkg.sv -----
// Shared types and constants of the direct form II IIR filter unit.
package iirdf2_pkg;

	// Filter order; taps above it are never read
	localparam int ORDER = 3;
	// Coefficient registers per side: gain plus three feedback, four feed-forward
	localparam int NUM_TAPS = 4;
	localparam int TAP_W = $clog2(NUM_TAPS);
	localparam int RING_DEPTH = ORDER + 1;
	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	localparam int COEF_W = 24;
	localparam int SAMPLE_W = 16;
	localparam int STATE_W = 32;
	localparam int PROD_W = COEF_W + STATE_W;
	// Four products of 56 bits plus sign growth
	localparam int ACC_W = PROD_W + 2;

	// Rounding points: state keeps 16 fraction bits, output 15, accumulator 36
	localparam int W_SHIFT = 20;
	localparam int Y_SHIFT = 21;
	localparam int W_FULL_W = ACC_W + 1 - W_SHIFT;
	localparam int Y_FULL_W = ACC_W + 1 - Y_SHIFT;

	localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FB3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FF0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FF1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FF2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FF3 = 3'd7;

	// Q4.20 value 1.0
	localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd1048576;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FB,
		S_FB_DRAIN,
		S_W_STORE,
		S_FF,
		S_FF_DRAIN,
		S_Y_OUT
	} state_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic              load_x;
		logic              mul_en;
		logic              phase_ff;
		logic [TAP_W-1:0]  tap;
		acc_op_t           acc_op;
		logic              w_store;
		logic              y_load;
	} cmd_t;

endpackage

// ----- hw/rtl/iir_direct_form_two_filter_unit.sv -----
// Top level of the direct form II IIR filter unit: configuration registers and core.
//
// Third-order direct form II IIR filter in fixed point. Each accepted
// transaction on the input channel carries one signed Q1.15 sample and
// produces exactly one transaction on the output channel: the filtered Q1.15
// sample and a flag that is set when either the internal state or the output
// was clipped. The intermediate value w = gain*x - sum a_i*w[n-i] is rounded
// half up to Q16.16, saturated to 32 bits and kept in a ring of ORDER+1
// entries that reset clears; the output y = sum b_i*w[n-i] is rounded half
// up to Q1.15 and saturated. One 24x32 multiplier with a registered product
// is shared by all taps, so a sample runs through these steps from one
// acceptance to the earliest next one: the idle state that takes it,
// ORDER+1 feedback multiplies, a drain of the product register, rounding
// and storing w, ORDER+1 feed-forward multiplies, a drain and the load
// of the output register. The output register parts the two sides, so a
// new sample is taken while an earlier result still waits; only the final
// load stalls when that result has not been taken yet.
// Coefficients are eight signed
// Q4.20 registers written through the configuration channel (index 0 gain,
// 1..3 feedback taps, 4 first feed-forward tap, 5..7 the rest); write them
// only while the filter is idle. Reset sets gain and first feed-forward tap
// to 1.0 and the rest to zero.
module iir_direct_form_two_filter_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                    saturated,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [iirdf2_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic signed [iirdf2_pkg::COEF_W-1:0]    cfg_data
);

	iirdf2_pkg::coef_t fb_coef_q [iirdf2_pkg::NUM_TAPS];
	iirdf2_pkg::coef_t ff_coef_q [iirdf2_pkg::NUM_TAPS];
	iirdf2_pkg::cmd_t  cmd;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	// Coefficient bank: decode the index and update one register per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iirdf2_pkg::NUM_TAPS; i++) begin
				fb_coef_q[i] <= '0;
				ff_coef_q[i] <= '0;
			end
			fb_coef_q[0] <= iirdf2_pkg::COEF_ONE;
			ff_coef_q[0] <= iirdf2_pkg::COEF_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iirdf2_pkg::REG_GAIN: fb_coef_q[0] <= cfg_data;
				iirdf2_pkg::REG_FB1:  fb_coef_q[1] <= cfg_data;
				iirdf2_pkg::REG_FB2:  fb_coef_q[2] <= cfg_data;
				iirdf2_pkg::REG_FB3:  fb_coef_q[3] <= cfg_data;
				iirdf2_pkg::REG_FF0:  ff_coef_q[0] <= cfg_data;
				iirdf2_pkg::REG_FF1:  ff_coef_q[1] <= cfg_data;
				iirdf2_pkg::REG_FF2:  ff_coef_q[2] <= cfg_data;
				iirdf2_pkg::REG_FF3:  ff_coef_q[3] <= cfg_data;
			endcase
		end
	end

	// Sequencer: walks the taps and drives the handshakes
	iirdf2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic, history ring and output register
	iirdf2_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.fb_coef    (fb_coef_q),
		.ff_coef    (ff_coef_q),
		.sample_out (sample_out),
		.saturated  (saturated)
	);

endmodule

// ----- hw/rtl/iirdf2_datapath.sv -----
// Datapath: shared multiplier, accumulator, history ring and output register.
module iirdf2_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iirdf2_pkg::cmd_t                       cmd,
	input  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_in,
	input  iirdf2_pkg::coef_t                      fb_coef [iirdf2_pkg::NUM_TAPS],
	input  iirdf2_pkg::coef_t                      ff_coef [iirdf2_pkg::NUM_TAPS],
	output logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                   saturated
);

	localparam int CALC_W = iirdf2_pkg::TAP_W + 1;

	logic signed [iirdf2_pkg::SAMPLE_W-1:0] x_q;
	logic signed [iirdf2_pkg::STATE_W-1:0]  ring_q [iirdf2_pkg::RING_DEPTH];
	logic [iirdf2_pkg::SLOT_W-1:0]          slot_q;
	logic signed [iirdf2_pkg::PROD_W-1:0]   prod_s1;
	iirdf2_pkg::acc_op_t                    op_s1;
	logic signed [iirdf2_pkg::ACC_W-1:0]    acc_q;
	logic                                   sat_w_q;
	logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                   saturated_q;

	logic [CALC_W-1:0]                      idx_calc;
	logic [iirdf2_pkg::SLOT_W-1:0]          ring_idx;
	iirdf2_pkg::coef_t                      coef_sel;
	logic signed [iirdf2_pkg::STATE_W-1:0]  opnd;
	logic signed [iirdf2_pkg::PROD_W-1:0]   prod_d;
	logic signed [iirdf2_pkg::ACC_W:0]      w_sum;
	logic signed [iirdf2_pkg::ACC_W:0]      y_sum;
	logic signed [iirdf2_pkg::W_FULL_W-1:0] w_full;
	logic signed [iirdf2_pkg::Y_FULL_W-1:0] y_full;
	logic signed [iirdf2_pkg::STATE_W-1:0]  w_sat;
	logic signed [iirdf2_pkg::SAMPLE_W-1:0] y_sat;
	logic                                   w_clip;
	logic                                   y_clip;

	// Tap j reads slot - j modulo ring depth
	always_comb begin
		idx_calc = CALC_W'(slot_q) + CALC_W'(iirdf2_pkg::RING_DEPTH) - CALC_W'(cmd.tap);
		if (idx_calc >= CALC_W'(iirdf2_pkg::RING_DEPTH)) begin
			idx_calc = idx_calc - CALC_W'(iirdf2_pkg::RING_DEPTH);
		end
		ring_idx = idx_calc[iirdf2_pkg::SLOT_W-1:0];
	end

	always_comb begin
		coef_sel = cmd.phase_ff ? ff_coef[cmd.tap] : fb_coef[cmd.tap];
		if (!cmd.phase_ff && cmd.tap == '0) begin
			// Input term enters as twice the sample
			opnd = iirdf2_pkg::STATE_W'(signed'({x_q, 1'b0}));
		end else begin
			opnd = ring_q[ring_idx];
		end
		prod_d = coef_sel * opnd;
	end

	// Round half up, then clip
	always_comb begin
		w_sum = (iirdf2_pkg::ACC_W+1)'(acc_q) + (iirdf2_pkg::ACC_W+1)'(1 << (iirdf2_pkg::W_SHIFT-1));
		y_sum = (iirdf2_pkg::ACC_W+1)'(acc_q) + (iirdf2_pkg::ACC_W+1)'(1 << (iirdf2_pkg::Y_SHIFT-1));
		w_full = signed'(w_sum[iirdf2_pkg::ACC_W:iirdf2_pkg::W_SHIFT]);
		y_full = signed'(y_sum[iirdf2_pkg::ACC_W:iirdf2_pkg::Y_SHIFT]);
		w_clip = 1'b1;
		y_clip = 1'b1;
		priority if (w_full > iirdf2_pkg::STATE_MAX) begin
			w_sat = iirdf2_pkg::STATE_MAX;
		end else if (w_full < iirdf2_pkg::STATE_MIN) begin
			w_sat = iirdf2_pkg::STATE_MIN;
		end else begin
			w_sat = w_full[iirdf2_pkg::STATE_W-1:0];
			w_clip = 1'b0;
		end
		priority if (y_full > iirdf2_pkg::SAMPLE_MAX) begin
			y_sat = iirdf2_pkg::SAMPLE_MAX;
		end else if (y_full < iirdf2_pkg::SAMPLE_MIN) begin
			y_sat = iirdf2_pkg::SAMPLE_MIN;
		end else begin
			y_sat = y_full[iirdf2_pkg::SAMPLE_W-1:0];
			y_clip = 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_s1 <= prod_d;
		end
		unique case (op_s1)
			iirdf2_pkg::ACC_LOAD: acc_q <= iirdf2_pkg::ACC_W'(prod_s1);
			iirdf2_pkg::ACC_ADD:  acc_q <= acc_q + iirdf2_pkg::ACC_W'(prod_s1);
			iirdf2_pkg::ACC_SUB:  acc_q <= acc_q - iirdf2_pkg::ACC_W'(prod_s1);
			iirdf2_pkg::ACC_HOLD: acc_q <= acc_q;
		endcase
		if (cmd.w_store) begin
			sat_w_q <= w_clip;
		end
		if (cmd.y_load) begin
			sample_out_q <= y_sat;
			saturated_q <= sat_w_q | y_clip;
		end
	end

	// Control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= iirdf2_pkg::ACC_HOLD;
			slot_q <= '0;
			for (int i = 0; i < iirdf2_pkg::RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			op_s1 <= cmd.mul_en ? cmd.acc_op : iirdf2_pkg::ACC_HOLD;
			if (cmd.w_store) begin
				ring_q[slot_q] <= w_sat;
			end
			if (cmd.y_load) begin
				slot_q <= (slot_q == iirdf2_pkg::SLOT_W'(iirdf2_pkg::ORDER)) ?
					'0 : slot_q + 1'b1;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign saturated = saturated_q;

	// A product is accumulated only in the cycle right after it was issued
	a_op_follows_mul: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.mul_en) |-> op_s1 == iirdf2_pkg::ACC_HOLD)
		else $error("accumulator moved without a fresh product");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= iirdf2_pkg::SLOT_W'(iirdf2_pkg::ORDER))
		else $error("ring slot beyond order");

	a_store_not_with_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.w_store && cmd.y_load))
		else $error("state store and output load in one cycle");

endmodule

// ----- hw/rtl/iirdf2_ctrl.sv -----
// Controller: sequences the feedback and feed-forward taps and owns the handshakes.
module iirdf2_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output iirdf2_pkg::cmd_t cmd
);

	iirdf2_pkg::state_t              state_q;
	iirdf2_pkg::state_t              state_d;
	logic [iirdf2_pkg::TAP_W-1:0]    tap_q;
	logic [iirdf2_pkg::TAP_W-1:0]    tap_d;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            last_tap;

	assign out_free = !out_valid_q || out_ready;
	assign last_tap = (tap_q == iirdf2_pkg::TAP_W'(iirdf2_pkg::ORDER));
	assign in_ready = (state_q == iirdf2_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirdf2_pkg::S_IDLE;
			tap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q <= tap_d;
			if (cmd.y_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		tap_d = tap_q;
		cmd = '0;
		cmd.tap = tap_q;
		cmd.acc_op = iirdf2_pkg::ACC_HOLD;
		unique case (state_q)
			iirdf2_pkg::S_IDLE: begin
				tap_d = '0;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_d = iirdf2_pkg::S_FB;
				end
			end
			iirdf2_pkg::S_FB: begin
				cmd.mul_en = 1'b1;
				cmd.acc_op = (tap_q == '0) ? iirdf2_pkg::ACC_LOAD : iirdf2_pkg::ACC_SUB;
				if (last_tap) begin
					tap_d = '0;
					state_d = iirdf2_pkg::S_FB_DRAIN;
				end else begin
					tap_d = tap_q + 1'b1;
				end
			end
			iirdf2_pkg::S_FB_DRAIN: begin
				state_d = iirdf2_pkg::S_W_STORE;
			end
			iirdf2_pkg::S_W_STORE: begin
				cmd.w_store = 1'b1;
				state_d = iirdf2_pkg::S_FF;
			end
			iirdf2_pkg::S_FF: begin
				cmd.mul_en = 1'b1;
				cmd.phase_ff = 1'b1;
				cmd.acc_op = (tap_q == '0) ? iirdf2_pkg::ACC_LOAD : iirdf2_pkg::ACC_ADD;
				if (last_tap) begin
					tap_d = '0;
					state_d = iirdf2_pkg::S_FF_DRAIN;
				end else begin
					tap_d = tap_q + 1'b1;
				end
			end
			iirdf2_pkg::S_FF_DRAIN: begin
				state_d = iirdf2_pkg::S_Y_OUT;
			end
			iirdf2_pkg::S_Y_OUT: begin
				// Hold until the output register is free
				if (out_free) begin
					cmd.y_load = 1'b1;
					state_d = iirdf2_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iirdf2_pkg::S_IDLE;
			end
		endcase
	end

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == iirdf2_pkg::S_Y_OUT))
		else $error("output valid raised outside the output state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == iirdf2_pkg::S_FB && tap_q == '0)
		else $error("accepted sample did not start the feedback pass");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q <= iirdf2_pkg::TAP_W'(iirdf2_pkg::ORDER))
		else $error("tap counter beyond order");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.y_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

// ----- test/iir_filter_checker.sv -----
`timescale 1ns / 100ps
// Watches the filter's channels, predicts each filtered sample and compares it with the output.
module iir_filter_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                    saturated,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [iirdf2_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic signed [iirdf2_pkg::COEF_W-1:0]    cfg_data,
	output int                                      outstanding,
	output int                                      mismatches
);
	import iirdf2_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} filtered_t;

	// Index 0 of the feedback side is the input gain
	coef_t fb_coef [0:ORDER];
	coef_t ff_coef [0:ORDER];
	logic signed [STATE_W-1:0] history [0:RING_DEPTH-1];
	int write_pos;
	filtered_t filtered_due [$];

	initial mismatches = 0;

	function automatic int slot_back(input int j);
		return (write_pos + RING_DEPTH - j) % RING_DEPTH;
	endfunction

	function automatic filtered_t filter_next(input logic signed [SAMPLE_W-1:0] x);
		filtered_t r;
		longint acc;
		longint w;
		longint y;
		r.clipped = 1'b0;
		// Products carry 36 fraction bits; the input term needs one extra shift
		acc = longint'(fb_coef[0]) * longint'(x) * 2;
		for (int j = 1; j <= ORDER; j++)
			acc -= longint'(fb_coef[j]) * longint'(history[slot_back(j)]);
		w = (acc + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
		if (w > longint'(STATE_MAX)) begin
			w = longint'(STATE_MAX);
			r.clipped = 1'b1;
		end else if (w < longint'(STATE_MIN)) begin
			w = longint'(STATE_MIN);
			r.clipped = 1'b1;
		end
		history[write_pos] = w[STATE_W-1:0];
		acc = 0;
		for (int j = 0; j <= ORDER; j++)
			acc += longint'(ff_coef[j]) * longint'(history[slot_back(j)]);
		y = (acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
		if (y > longint'(SAMPLE_MAX)) begin
			y = longint'(SAMPLE_MAX);
			r.clipped = 1'b1;
		end else if (y < longint'(SAMPLE_MIN)) begin
			y = longint'(SAMPLE_MIN);
			r.clipped = 1'b1;
		end
		r.sample = y[SAMPLE_W-1:0];
		write_pos = (write_pos >= ORDER) ? 0 : write_pos + 1;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int want, input int got);
		if (mismatches < 100)
			$display("%0t checker: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_t due;
		if (!arst_n) begin
			fb_coef[0] = COEF_ONE;
			ff_coef[0] = COEF_ONE;
			for (int j = 1; j <= ORDER; j++) begin
				fb_coef[j] = '0;
				ff_coef[j] = '0;
			end
			for (int j = 0; j < RING_DEPTH; j++)
				history[j] = '0;
			write_pos = 0;
			filtered_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN: fb_coef[0] = cfg_data;
					REG_FB1:  fb_coef[1] = cfg_data;
					REG_FB2:  fb_coef[2] = cfg_data;
					REG_FB3:  fb_coef[3] = cfg_data;
					REG_FF0:  ff_coef[0] = cfg_data;
					REG_FF1:  ff_coef[1] = cfg_data;
					REG_FF2:  ff_coef[2] = cfg_data;
					REG_FF3:  ff_coef[3] = cfg_data;
					default: ;
				endcase
			end
			// Compare before predicting, so a sample taken this edge is not matched
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					report_mismatch("unexpected output, sample_out", 0, int'(sample_out));
				end else begin
					due = filtered_due.pop_front();
					if (sample_out !== due.sample)
						report_mismatch("sample_out", int'(due.sample), int'(sample_out));
					if (saturated !== due.clipped)
						report_mismatch("saturated", int'(due.clipped), int'(saturated));
				end
			end
			if (in_valid && in_ready)
				filtered_due.push_back(filter_next(sample_in));
			outstanding <= filtered_due.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the filter testbench: clock, reset, sample and coefficient traffic, and the verdict.
module testbench;
	import iirdf2_pkg::*;

	// Far above the slowest correct run: ~730 samples with long gaps and long stalls
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int SAMPLES_PER_PHASE = 88;
	// Cycles one sample spends inside the core
	localparam int CORE_CYCLES = 2 * ORDER + 7;

	localparam coef_t COEF_TOP = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t COEF_BOTTOM = {1'b1, {(COEF_W-1){1'b0}}};
	localparam coef_t COEF_HALF = 24'sd524288;

	// Coefficient sets for the random phases
	typedef enum int {
		SET_STABLE,
		SET_WILD,
		SET_CORNER
	} setting_e;

	// Output-side stall patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} stall_e;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic saturated;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	coef_t cfg_data;

	int outstanding;
	int mismatches;
	int cycles = 0;
	// Samples left in the current input burst
	int burst_left = 0;

	iir_direct_form_two_filter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	iir_filter_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.saturated   (saturated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the filter hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Output side: switch stall pattern at random intervals, so that back pressure
	// hits the final output load, with open stretches in between.
	initial begin
		stall_e mode;
		int seg_left;
		int hold;
		mode = RX_OPEN;
		seg_left = 0;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode = stall_e'($urandom_range(0, 3));
				seg_left = $urandom_range(50, 300);
			end
			seg_left--;
			case (mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
				default: begin
					// Long stall, then open for a single cycle
					if (hold == 0) begin
						hold = $urandom_range(1, 40);
						out_ready <= 1'b1;
					end else begin
						hold--;
						out_ready <= 1'b0;
					end
				end
			endcase
		end
	end

	// Write one coefficient register; hold the transaction until it is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_sel, input coef_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_sel;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_coefs(input coef_t gain, input coef_t a1, input coef_t a2,
			input coef_t a3, input coef_t b0, input coef_t b1, input coef_t b2, input coef_t b3);
		write_reg(REG_GAIN, gain);
		write_reg(REG_FB1, a1);
		write_reg(REG_FB2, a2);
		write_reg(REG_FB3, a3);
		write_reg(REG_FF0, b0);
		write_reg(REG_FF1, b1);
		write_reg(REG_FF2, b2);
		write_reg(REG_FF3, b3);
	endtask

	// Send one sample. Bursts of random length; before most bursts drop valid for a random gap.
	// Within a burst keep valid high and advance the payload only after acceptance.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 30);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// Drop valid and wait until every predicted output has been taken; the filter is idle then.
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly full-range noise, with small values and the extremes mixed in
	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
		if (pick < 4) begin
			case ($urandom_range(0, 3))
				0: return SAMPLE_MAX;
				1: return SAMPLE_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		return SAMPLE_W'($urandom);
	endfunction

	// Stable sets keep taps within +-span so the output does not sit at the rails
	function automatic coef_t pick_coef(input setting_e kind, input int span);
		case (kind)
			SET_STABLE: return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
			SET_WILD: return COEF_W'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0: return COEF_TOP;
					1: return COEF_BOTTOM;
					2: return '0;
					3: return COEF_ONE;
					default: return -COEF_ONE;
				endcase
			end
		endcase
	endfunction

	task automatic load_setting(input setting_e kind);
		// Feedback taps within +-0.25 keep the stable sets stable
		load_coefs(pick_coef(kind, 2097152), pick_coef(kind, 262144),
			pick_coef(kind, 262144), pick_coef(kind, 262144),
			pick_coef(kind, 1048576), pick_coef(kind, 1048576),
			pick_coef(kind, 1048576), pick_coef(kind, 1048576));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GAIN;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset coefficients pass the sample straight through
		send_sample(16'sd0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_sample(16'sd0);

		// Half gains keep the state exact and put the output rounding a quarter off the half point
		drain();
		load_coefs(COEF_HALF, '0, '0, '0, COEF_HALF, '0, '0, '0);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd3);
		send_sample(-16'sd3);

		// Extreme taps: the state runs into both rails and the output clips both ways,
		// and the run is long enough to wrap the history ring
		drain();
		load_coefs(COEF_TOP, COEF_TOP, '0, '0, COEF_TOP, COEF_BOTTOM, '0, COEF_ONE);
		repeat (6) send_sample(SAMPLE_MAX);
		repeat (6) send_sample(SAMPLE_MIN);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			load_setting(setting_e'(p % 3));
			repeat (SAMPLES_PER_PHASE) send_sample(random_sample());
		end

		drain();
		// Give a stray extra output time to show up
		repeat (CORE_CYCLES + 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
